FILE: sv/gaussian_rotation_velocity_profile_core_macros.svh
// assertion macros for the rotation velocity profile core
`ifndef GAUSSIAN_ROTATION_VELOCITY_PROFILE_CORE_MACROS_SVH
`define GAUSSIAN_ROTATION_VELOCITY_PROFILE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define GRVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRVP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRVP_ASSERT(lbl, prop, msg)
`define GRVP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/grvp_pkg.sv
// shared constants and types for the rotation velocity profile core
package grvp_pkg;

  localparam int ANGLE_W   = 20;
  localparam int VEL_W     = 16;
  localparam int CFG_W     = 15;
  localparam int PI_Q      = 12868;
  localparam int TWO_PI_Q  = 25736;
  localparam int ONE_Q     = 16384;
  localparam int EXP_CUT   = 24;
  localparam int SERIES_N  = 16;
  localparam int MUL_W     = 33;
  localparam int REM_W     = 31;
  localparam int SH_W      = 33;
  localparam int CNT_W     = 6;

  typedef enum logic [1:0] {
    CFG_TARGET,
    CFG_EFFORT,
    CFG_WIDTH,
    CFG_MODE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MODL,
    S_MODW,
    S_DIFF,
    S_SQD,
    S_SQC,
    S_XL,
    S_XW,
    S_TM,
    S_TD,
    S_TW,
    S_KL,
    S_KA,
    S_P,
    S_PA
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: sv/gaussian_rotation_velocity_profile_core.sv
// top level: sequencer and datapath of the gaussian rotation velocity profile
//
// channel | dir | handshake              | word
// in      | in  | in_valid / in_ready    | in_needle_angle
// out     | out | out_valid / out_ready  | out_rotation_velocity, out_turning_ccw
// cfg     | in  | cfg_we                 | cfg_index, cfg_wdata
//
// a word that reaches the series runs the exponent divide, 32 series terms and one
// multiply per unit of k, k the exponent's integer part (0 to 23); a word past the
// exponent cutoff skips the series, and unidirectional mode adds the angle remainder;
// in_ready returns once the sequencer is back in idle
// reset clears configuration to its defaults, the direction bit and the sequencer
// a finished result waits in the output register; the next word is accepted meanwhile
`include "gaussian_rotation_velocity_profile_core_macros.svh"
module gaussian_rotation_velocity_profile_core
  import grvp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [ANGLE_W-1:0] in_needle_angle,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VEL_W-1:0]  out_rotation_velocity,
  output logic                     out_turning_ccw,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] target_r, effort_r, width_r;
  logic             mode_r;
  logic             dir_r, dir_nxt;

  logic signed [ANGLE_W-1:0] theta_r, theta_nxt;
  logic [19:0]      ad_r, ad_nxt;
  logic [39:0]      d2_r, d2_nxt;
  logic [20:0]      x_r, x_nxt;
  logic             cut_r, cut_nxt;
  logic [32:0]      term_r, term_nxt;
  logic signed [34:0] sum_r, sum_nxt;
  logic [4:0]       n_r, n_nxt;
  logic [16:0]      f_r, f_nxt;
  logic             sel_r, sel_nxt;
  logic [32:0]      einv_r, einv_nxt;
  logic [32:0]      r_r, r_nxt;
  logic [4:0]       k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [VEL_W-1:0] out_vel_r, out_vel_nxt;
  logic             out_ccw_r, out_ccw_nxt;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  div_ctl_t           div_ctl;
  div_sts_t           div_sts;
  logic [REM_W-1:0]   div_rem_init, div_divisor;
  logic [SH_W-1:0]    div_dividend, div_quo;

  logic [19:0]        theta_abs, mod_sub, mod_dif, mod_rem, theta_mod;
  logic signed [20:0] d_raw, d_w, d_neg;
  logic [19:0]        ad;
  logic [CFG_W-1:0]   c_eff;
  logic [55:0]        num;
  logic [30:0]        dd;
  logic               ovf;
  logic signed [34:0] sum_n;
  logic [32:0]        clamp;
  logic [65:0]        rnd;
  logic [14:0]        p;
  logic signed [16:0] w, mag, velb;
  logic signed [VEL_W-1:0] vel;

  grvp_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  grvp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quo      (div_quo),
    .sts      (div_sts)
  );

  assign theta_abs = theta_r[ANGLE_W-1] ? (~theta_r + 20'd1) : theta_r;
  assign mod_sub   = 20'(TWO_PI_Q) << n_r[2:0];
  assign mod_dif   = ad_r - mod_sub;
  assign mod_rem   = (ad_r >= mod_sub) ? mod_dif : ad_r;
  assign theta_mod = theta_r[ANGLE_W-1] ? (~mod_rem + 20'd1) : mod_rem;
  assign d_raw     = {theta_r[ANGLE_W-1], theta_r} - $signed({6'b0, target_r});
  assign d_w       = (d_raw > $signed(21'(PI_Q))) ? ($signed(21'(TWO_PI_Q)) - d_raw) : d_raw;
  assign d_neg     = -d_w;
  assign ad        = d_w[20] ? d_neg[19:0] : d_w[19:0];
  assign c_eff     = (width_r == '0) ? CFG_W'(1) : width_r;
  assign num       = {d2_r, 16'b0} + {26'b0, prod[29:0]};
  assign dd        = {prod[29:0], 1'b0};
  assign ovf       = num[55:21] >= {4'b0, dd};
  assign sum_n     = n_r[0] ? (sum_r - $signed({2'b0, div_quo})) :
                              (sum_r + $signed({2'b0, div_quo}));
  assign clamp     = sum_n[34] ? 33'd0 : sum_n[32:0];
  assign rnd       = prod + (66'd1 << 31);
  assign p         = rnd[46:32];
  assign w         = $signed(17'(ONE_Q)) - $signed({2'b0, p});
  assign mag       = w[16] ? -w : w;
  assign velb      = mode_r ? (dir_r ? -mag : mag) : w;
  assign vel       = (velb > 17'sd32767) ? 16'sh7fff :
                     (velb < -17'sd32768) ? 16'sh8000 : velb[15:0];

  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    theta_nxt     = theta_r;
    ad_nxt        = ad_r;
    d2_nxt        = d2_r;
    x_nxt         = x_r;
    cut_nxt       = cut_r;
    term_nxt      = term_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    f_nxt         = f_r;
    sel_nxt       = sel_r;
    einv_nxt      = einv_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vel_nxt   = out_vel_r;
    out_ccw_nxt   = out_ccw_r;
    mul_a         = '0;
    mul_b         = '0;
    div_ctl       = '0;
    div_rem_init  = '0;
    div_dividend  = '0;
    div_divisor   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          theta_nxt = in_needle_angle;
          if (mode_r) begin
            if (in_needle_angle > $signed(20'(TWO_PI_Q))) begin
              dir_nxt = 1'b1;
            end else if (in_needle_angle < 20'sd0) begin
              dir_nxt = 1'b0;
            end
            state_nxt = S_DIFF;
          end else begin
            state_nxt = S_MODL;
          end
        end
      end
      S_MODL: begin
        ad_nxt    = theta_abs;
        n_nxt     = 5'd4;
        state_nxt = S_MODW;
      end
      S_MODW: begin
        // subtract 2pi scaled by 16, 8, 4, 2, 1
        ad_nxt = mod_rem;
        n_nxt  = n_r - 5'd1;
        if (n_r == 5'd0) begin
          theta_nxt = theta_mod;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        ad_nxt    = ad;
        state_nxt = S_SQD;
      end
      S_SQD: begin
        mul_a     = {13'b0, ad_r};
        mul_b     = {13'b0, ad_r};
        state_nxt = S_SQC;
      end
      S_SQC: begin
        d2_nxt    = prod[39:0];
        mul_a     = {18'b0, c_eff};
        mul_b     = {18'b0, c_eff};
        state_nxt = S_XL;
      end
      S_XL: begin
        if (ovf) begin
          cut_nxt   = 1'b1;
          state_nxt = S_P;
        end else begin
          cut_nxt       = 1'b0;
          div_ctl.start = 1'b1;
          div_ctl.steps = CNT_W'(21);
          div_rem_init  = num[51:21];
          div_dividend  = {num[20:0], 12'b0};
          div_divisor   = dd;
          state_nxt     = S_XW;
        end
      end
      S_XW: begin
        if (div_sts.done) begin
          x_nxt = div_quo[20:0];
          if (div_quo[20:16] >= 5'(EXP_CUT)) begin
            cut_nxt   = 1'b1;
            state_nxt = S_P;
          end else begin
            k_nxt     = div_quo[20:16];
            term_nxt  = 33'h1_0000_0000;
            sum_nxt   = 35'sh1_0000_0000;
            n_nxt     = 5'd1;
            f_nxt     = 17'h1_0000;
            sel_nxt   = 1'b0;
            state_nxt = S_TM;
          end
        end
      end
      S_TM: begin
        mul_a     = term_r;
        mul_b     = {16'b0, f_r};
        state_nxt = S_TD;
      end
      S_TD: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = CNT_W'(33);
        div_dividend  = prod[48:16];
        div_divisor   = {26'b0, n_r};
        state_nxt     = S_TW;
      end
      S_TW: begin
        if (div_sts.done) begin
          term_nxt = div_quo;
          sum_nxt  = sum_n;
          if (n_r == 5'(SERIES_N)) begin
            if (!sel_r) begin
              einv_nxt  = clamp;
              term_nxt  = 33'h1_0000_0000;
              sum_nxt   = 35'sh1_0000_0000;
              n_nxt     = 5'd1;
              f_nxt     = {1'b0, x_r[15:0]};
              sel_nxt   = 1'b1;
              state_nxt = S_TM;
            end else begin
              r_nxt     = clamp;
              state_nxt = S_KL;
            end
          end else begin
            n_nxt     = n_r + 5'd1;
            state_nxt = S_TM;
          end
        end
      end
      S_KL: begin
        if (k_r == '0) begin
          state_nxt = S_P;
        end else begin
          mul_a     = r_r;
          mul_b     = einv_r;
          state_nxt = S_KA;
        end
      end
      S_KA: begin
        r_nxt     = rnd[64:32];
        k_nxt     = k_r - 5'd1;
        state_nxt = S_KL;
      end
      S_P: begin
        mul_a     = {18'b0, effort_r};
        mul_b     = cut_r ? '0 : r_r;
        state_nxt = S_PA;
      end
      S_PA: begin
        mul_a = {18'b0, effort_r};
        mul_b = cut_r ? '0 : r_r;
        if (!out_valid_r || out_ready) begin
          out_vel_nxt   = vel;
          out_ccw_nxt   = dir_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_r       <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= '0;
      effort_r    <= '0;
      width_r     <= CFG_W'(2048);
      mode_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET: target_r <= cfg_wdata;
          CFG_EFFORT: effort_r <= cfg_wdata;
          CFG_WIDTH:  width_r  <= cfg_wdata;
          CFG_MODE:   mode_r   <= cfg_wdata[0];
          default:    mode_r   <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    theta_r   <= theta_nxt;
    ad_r      <= ad_nxt;
    d2_r      <= d2_nxt;
    x_r       <= x_nxt;
    cut_r     <= cut_nxt;
    term_r    <= term_nxt;
    sum_r     <= sum_nxt;
    n_r       <= n_nxt;
    f_r       <= f_nxt;
    sel_r     <= sel_nxt;
    einv_r    <= einv_nxt;
    r_r       <= r_nxt;
    k_r       <= k_nxt;
    out_vel_r <= out_vel_nxt;
    out_ccw_r <= out_ccw_nxt;
  end

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_rotation_velocity = out_vel_r;
  assign out_turning_ccw       = out_ccw_r;

  `GRVP_ASSERT(a_div_done_wait, div_sts.done |-> (state_r == S_XW || state_r == S_TW), "divider done outside wait")
  `GRVP_ASSERT(a_series_index, (state_r == S_TD) |-> (n_r != 5'd0 && n_r <= 5'(SERIES_N)), "series term index out of range")
  `GRVP_ASSERT(a_unit_count, (state_r == S_KL) |-> (k_r < 5'(EXP_CUT)), "exponent unit count past cutoff")
  `GRVP_ASSERT(a_uni_dir_held, (in_valid && in_ready && !mode_r) |=> $stable(dir_r), "direction changed in unidirectional mode")
  `GRVP_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "sequencer not idle after reset")

endmodule

FILE: sv/grvp_mul.sv
// shared registered multiplier
module grvp_mul
  import grvp_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

FILE: sv/grvp_div.sv
// shared bit-serial restoring divider
module grvp_div
  import grvp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [REM_W-1:0] rem_init,
  input  logic [SH_W-1:0]  dividend,
  input  logic [REM_W-1:0] divisor,
  output logic [SH_W-1:0]  quo,
  output div_sts_t         sts
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [REM_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REM_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, sh_r[SH_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      rem_nxt  = rem_init;
      sh_nxt   = dividend;
      div_nxt  = divisor;
      cnt_nxt  = ctl.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? REM_W'(trial - {1'b0, div_r}) : trial[REM_W-1:0];
      sh_nxt  = {sh_r[SH_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
  end

  assign quo      = sh_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: bench/gaussian_rotation_velocity_profile_core_tb.sv
// testbench for the gaussian rotation velocity profile core with a built-in predictor
`timescale 1ns / 100ps
module gaussian_rotation_velocity_profile_core_tb;
  import grvp_pkg::*;

  typedef struct {
    logic signed [VEL_W-1:0] velocity;
    logic                    ccw;
  } velocity_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_needle_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VEL_W-1:0]   out_rotation_velocity;
  logic                      out_turning_ccw;
  logic                      cfg_we = 1'b0;
  cfg_idx_t                  cfg_index = CFG_TARGET;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  logic signed [ANGLE_W-1:0] angle_queue[$];
  velocity_word_t            velocity_queue[$];
  int                        error_count = 0;
  int                        words_seen = 0;
  int                        burst_left = 0;
  int                        gap_left = 0;
  int                        hold_left = 0;
  int                        stall_mode = 0;
  int                        stall_left = 0;
  bit                        long_hold_done = 1'b0;

  longint unsigned mdl_target, mdl_effort, mdl_width;
  bit              mdl_mode, mdl_ccw;

  gaussian_rotation_velocity_profile_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_needle_angle,
    .out_valid, .out_ready, .out_rotation_velocity, .out_turning_ccw,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  function automatic longint unsigned series_exp(longint unsigned f);
    longint unsigned term;
    longint          sum;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int n = 1; n <= SERIES_N; n++) begin
      term = ((term * f) >> 16) / n;
      if (n % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  function automatic longint unsigned gauss_exp(longint unsigned x);
    longint unsigned r, einv, k;
    k = x >> 16;
    if (k >= EXP_CUT) return 0;
    r = series_exp(x & 64'hFFFF);
    einv = series_exp(64'd65536);
    for (longint unsigned i = 0; i < k; i++) r = (r * einv + (64'd1 << 31)) >> 32;
    return r;
  endfunction

  function automatic longint profile_velocity(longint theta);
    longint          d;
    longint unsigned ad, c, c2, x, p;
    d = theta - longint'(mdl_target);
    if (d > PI_Q) d = TWO_PI_Q - d;
    ad = (d < 0) ? -d : d;
    c = (mdl_width != 0) ? mdl_width : 1;
    c2 = c * c;
    x = (((ad * ad) << 16) + c2) / (2 * c2);
    p = (mdl_effort * gauss_exp(x) + (64'd1 << 31)) >> 32;
    return longint'(ONE_Q) - longint'(p);
  endfunction

  function automatic velocity_word_t predict_velocity(logic signed [ANGLE_W-1:0] angle);
    velocity_word_t res;
    longint         theta, w;
    theta = angle;
    if (!mdl_mode) begin
      w = profile_velocity(theta % TWO_PI_Q);
    end else begin
      if (theta > TWO_PI_Q) mdl_ccw = 1'b1;
      else if (theta < 0) mdl_ccw = 1'b0;
      w = profile_velocity(theta);
      if (w < 0) w = -w;
      if (mdl_ccw) w = -w;
    end
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    res.velocity = w[VEL_W-1:0];
    res.ccw = mdl_ccw;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_seen, what, got, want);
    error_count++;
  endtask

  // sender: bursts with gaps
  always @(posedge clk) begin
    bit nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        velocity_queue.push_back(predict_velocity(in_needle_angle));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (angle_queue.size() > 0) begin
          in_needle_angle <= angle_queue.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // receiver: stall pattern plus one long hold
  always @(posedge clk) begin
    velocity_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (velocity_queue.size() == 0) begin
          report_mismatch("unexpected word", out_rotation_velocity, 0);
        end else begin
          want = velocity_queue.pop_front();
          if (out_rotation_velocity !== want.velocity)
            report_mismatch("velocity", out_rotation_velocity, want.velocity);
          if (out_turning_ccw !== want.ccw)
            report_mismatch("turning_ccw", out_turning_ccw, want.ccw);
        end
        words_seen++;
      end
      if (!long_hold_done && words_seen == 40) begin
        long_hold_done = 1'b1;
        hold_left = 6000;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 3000);
      end else begin
        stall_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ready <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    case (idx)
      CFG_TARGET: mdl_target = value[CFG_W-1:0];
      CFG_EFFORT: mdl_effort = value[CFG_W-1:0];
      CFG_WIDTH:  mdl_width = value[CFG_W-1:0];
      CFG_MODE:   mdl_mode = value[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_profile(int unsigned target, int unsigned effort, int unsigned width,
                             bit mode);
    write_reg(CFG_TARGET, target);
    write_reg(CFG_EFFORT, effort);
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_MODE, mode);
  endtask

  task automatic drain;
    while (angle_queue.size() > 0 || in_valid || velocity_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) angle_queue.push_back($urandom_range(0, 60000) - 20000);
      else if (sel < 8) angle_queue.push_back($urandom_range(0, 12000) - 6000
                                              + $urandom_range(0, 2) * TWO_PI_Q);
      else angle_queue.push_back($urandom);
    end
  endtask

  initial begin
    mdl_target = 0;
    mdl_effort = 0;
    mdl_width = 2048;
    mdl_mode = 1'b1;
    mdl_ccw = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults first, then directed extremes
    angle_queue = '{-524288, 524287, 0, -1, 1, PI_Q, PI_Q + 1, TWO_PI_Q, TWO_PI_Q + 1,
                    -TWO_PI_Q, 100000, -100000};
    drain();
    set_profile(TWO_PI_Q, 16384, 0, 1'b1);
    angle_queue = '{0, TWO_PI_Q, TWO_PI_Q + 1, 30000, -5, 12000, -524288};
    drain();
    set_profile(PI_Q, 16384, 32767, 1'b0);
    angle_queue = '{-524288, 524287, PI_Q, -PI_Q, TWO_PI_Q + PI_Q, 0};
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: set_profile($urandom_range(0, TWO_PI_Q), $urandom_range(0, 16384),
                       $urandom_range(1, 32767), $urandom_range(0, 1));
        1: set_profile(0, 16384, $urandom_range(1, 4096), 1'b1);
        2: set_profile(TWO_PI_Q, $urandom_range(0, 32767), $urandom_range(0, 400), 1'b0);
        default: set_profile($urandom_range(0, 32767), $urandom_range(8000, 16384),
                             $urandom_range(500, 32767), $urandom_range(0, 1));
      endcase
      push_random(118);
      drain();
    end

    repeat (1500) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: gaussian_rotation_velocity_profile_core.f
+incdir+sv
sv/grvp_pkg.sv
sv/grvp_mul.sv
sv/grvp_div.sv
sv/gaussian_rotation_velocity_profile_core.sv
bench/gaussian_rotation_velocity_profile_core_tb.sv
